// ===== rtl/core/dss_pkg.sv =====
// shared types, constants and codes for the dual stack shared buffer
package dss_pkg;

	// buffer geometry
	localparam int DEPTH      = 256;
	localparam int DATA_WIDTH = 32;
	localparam int ADDR_W     = $clog2(DEPTH);
	localparam int CNT_W      = 9;
	localparam int SUM_W      = CNT_W + 1;

	// operation codes
	localparam logic [1:0] OP_PUSH = 2'd0;
	localparam logic [1:0] OP_POP  = 2'd1;
	localparam logic [1:0] OP_TOP  = 2'd2;

	// status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_UNDER = 2'd1;
	localparam logic [1:0] STAT_OVER  = 2'd2;

	// request word
	typedef struct packed {
		logic [1:0]  operation;
		logic        stack_select;
		logic [31:0] push_value;
	} cmd_word_t;

	// response word
	typedef struct packed {
		logic [31:0] top_value;
		logic [1:0]  status;
		logic [8:0]  size_one;
		logic [8:0]  size_two;
	} rsp_word_t;

	// controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_LOAD
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic load_item;
		logic exec;
		logic load_out;
	} dp_cmd_t;

endpackage

// ===== rtl/core/dss_datapath.sv =====
// datapath: request register, stack counters, shared buffer and response register
module dss_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  dss_pkg::dp_cmd_t   ctl,
	input  dss_pkg::cmd_word_t cmd,
	output dss_pkg::rsp_word_t rsp
);

	dss_pkg::cmd_word_t item_q;
	logic [dss_pkg::CNT_W-1:0]      count_one_q;
	logic [dss_pkg::CNT_W-1:0]      count_two_q;
	logic [dss_pkg::DATA_WIDTH-1:0] buf_mem [dss_pkg::DEPTH];
	logic [dss_pkg::DATA_WIDTH-1:0] rd_data_q;
	logic [1:0]                     status_q;
	logic                           top_ok_q;
	dss_pkg::rsp_word_t             rsp_q;

	logic [dss_pkg::CNT_W-1:0]  cnt_sel;
	logic [dss_pkg::CNT_W-1:0]  cnt_dec;
	logic [dss_pkg::SUM_W-1:0]  cnt_sum;
	logic                       full;
	logic                       empty;
	logic                       is_push;
	logic                       is_read;
	logic [dss_pkg::ADDR_W-1:0] push_addr;
	logic [dss_pkg::ADDR_W-1:0] top_addr;
	logic                       do_write;
	logic                       do_read;
	logic [dss_pkg::DATA_WIDTH-1:0] wr_data;

	// decode of the held request against the current counts
	always_comb begin
		cnt_sel   = item_q.stack_select ? count_two_q : count_one_q;
		cnt_dec   = cnt_sel - dss_pkg::CNT_W'(1);
		cnt_sum   = dss_pkg::SUM_W'(count_one_q) + dss_pkg::SUM_W'(count_two_q);
		full      = cnt_sum >= dss_pkg::SUM_W'(dss_pkg::DEPTH);
		empty     = cnt_sel == '0;
		is_push   = item_q.operation == dss_pkg::OP_PUSH;
		is_read   = item_q.operation inside {dss_pkg::OP_POP, dss_pkg::OP_TOP};
		// stack two counts down from the last entry
		push_addr = item_q.stack_select ?
			(dss_pkg::ADDR_W'(dss_pkg::DEPTH - 1) - cnt_sel[dss_pkg::ADDR_W-1:0]) :
			cnt_sel[dss_pkg::ADDR_W-1:0];
		top_addr  = item_q.stack_select ?
			(dss_pkg::ADDR_W'(dss_pkg::DEPTH - 1) - cnt_dec[dss_pkg::ADDR_W-1:0]) :
			cnt_dec[dss_pkg::ADDR_W-1:0];
		do_write  = ctl.exec && is_push && !full;
		do_read   = ctl.exec && is_read && !empty;
		wr_data   = item_q.push_value[dss_pkg::DATA_WIDTH-1:0];
	end

	// request capture
	always_ff @(posedge clk) begin
		if (ctl.load_item) begin
			item_q <= cmd;
		end
	end

	// shared buffer, one access per request
	always_ff @(posedge clk) begin
		if (do_write) begin
			buf_mem[push_addr] <= wr_data;
		end
		if (do_read) begin
			rd_data_q <= buf_mem[top_addr];
		end
	end

	// stack counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_one_q <= '0;
			count_two_q <= '0;
		end else if (ctl.exec) begin
			if (do_write) begin
				if (item_q.stack_select) count_two_q <= count_two_q + dss_pkg::CNT_W'(1);
				else                     count_one_q <= count_one_q + dss_pkg::CNT_W'(1);
			end else if (do_read && item_q.operation == dss_pkg::OP_POP) begin
				if (item_q.stack_select) count_two_q <= cnt_dec;
				else                     count_one_q <= cnt_dec;
			end
		end
	end

	// status of the executed request
	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			top_ok_q <= do_read;
			if (is_push && full)       status_q <= dss_pkg::STAT_OVER;
			else if (is_read && empty) status_q <= dss_pkg::STAT_UNDER;
			else                       status_q <= dss_pkg::STAT_OK;
		end
	end

	// response register
	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			rsp_q.top_value <= top_ok_q ? 32'(rd_data_q) : '0;
			rsp_q.status    <= status_q;
			rsp_q.size_one  <= count_one_q;
			rsp_q.size_two  <= count_two_q;
		end
	end

	assign rsp = rsp_q;

endmodule

// ===== rtl/core/dss_ctrl.sv =====
// controller: request sequencing and response word handshake
module dss_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_stall,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output dss_pkg::dp_cmd_t ctl
);

	dss_pkg::state_t state_q;
	dss_pkg::state_t state_nxt;
	logic            rsp_valid_q;
	logic            rsp_free;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dss_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state and datapath commands
	always_comb begin
		state_nxt     = state_q;
		ctl           = '0;
		cmd_stall     = 1'b1;
		rsp_free      = !rsp_valid_q || !rsp_stall;
		case (state_q)
			dss_pkg::S_IDLE: begin
				cmd_stall = 1'b0;
				if (cmd_valid) begin
					ctl.load_item = 1'b1;
					state_nxt     = dss_pkg::S_EXEC;
				end
			end
			dss_pkg::S_EXEC: begin
				ctl.exec  = 1'b1;
				state_nxt = dss_pkg::S_LOAD;
			end
			dss_pkg::S_LOAD: begin
				if (rsp_free) begin
					ctl.load_out = 1'b1;
					state_nxt    = dss_pkg::S_IDLE;
				end
			end
			default: begin
				state_nxt = dss_pkg::S_IDLE;
			end
		endcase
	end

	// response word valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctl.load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

// ===== rtl/core/dual_stack_shared_buffer.sv =====
// top level of the dual stack shared buffer
// Two stacks share one 256-word buffer: stack one grows up from entry zero,
// stack two grows down from the last entry. Each request word on the cmd
// channel names an operation (push, pop, read top) and a stack; each request
// gives exactly one response word on the rsp channel with the top before a
// pop or read top (zero otherwise), a status and both stack sizes after it.
// Both channels use valid/stall: a word moves on a rising edge with valid
// high and stall low.
// An accepted request passes the buffer access step and then the response
// load step, which waits while an earlier response word is still stalled.
// The controller takes no new request until it has gone through its accept,
// buffer access and response load steps.
// A new request is taken while the previous response word still waits;
// while rsp is stalled the response register holds and the following
// request waits in its last step, during which cmd_stall stays high.
// Reset clears both stack counts and all handshake state; buffer contents
// are left as they are and are only read once pushed.
module dual_stack_shared_buffer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  dss_pkg::cmd_word_t cmd,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output dss_pkg::rsp_word_t rsp
);

	dss_pkg::dp_cmd_t ctl;

	// sequencing
	dss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.ctl       (ctl)
	);

	// storage and counters
	dss_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.cmd    (cmd),
		.rsp    (rsp)
	);

endmodule

// ===== bench/tb.sv =====
// self-checking testbench for the dual stack shared buffer
`timescale 1ns / 1ps

module tb;
	import dss_pkg::*;

	// unused operation code, answered as a no-op
	localparam logic [1:0] OP_NONE = 2'd3;

	localparam int ITEM_TARGET = 1750;
	localparam int IDLE_LIMIT  = 2000;
	localparam int HOLD_CYCLES = 80;

	typedef struct {
		cmd_word_t w;
		bit        fixed;
		rsp_word_t r;
	} dir_row_t;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      cmd_valid;
	logic      cmd_stall;
	cmd_word_t cmd;
	logic      rsp_valid;
	logic      rsp_stall;
	rsp_word_t rsp;

	// shadow copy of the two stacks
	logic [31:0] stack_mem [DEPTH];
	int unsigned n_one = 0;
	int unsigned n_two = 0;

	rsp_word_t expected_q [$];
	rsp_word_t want_rsp;
	int        fail_count  = 0;
	int        items_sent  = 0;
	int        idle_cycles = 0;
	bit        burst_mode  = 1'b0;
	bit        hold_now    = 1'b0;
	dir_row_t  dir_rows [$];

	dual_stack_shared_buffer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// next response of the stacks for one request word
	function automatic rsp_word_t step_stacks(input cmd_word_t w);
		rsp_word_t   r;
		int unsigned cnt;
		int unsigned slot;
		r        = '0;
		r.status = STAT_OK;
		cnt      = w.stack_select ? n_two : n_one;
		case (w.operation)
			OP_PUSH: begin
				if (n_one + n_two >= DEPTH) begin
					r.status = STAT_OVER;
				end else begin
					slot = w.stack_select ? DEPTH - 1 - cnt : cnt;
					stack_mem[slot] = w.push_value;
					cnt++;
				end
			end
			OP_POP, OP_TOP: begin
				if (cnt == 0) begin
					r.status = STAT_UNDER;
				end else begin
					slot = w.stack_select ? DEPTH - cnt : cnt - 1;
					r.top_value = stack_mem[slot];
					if (w.operation == OP_POP)
						cnt--;
				end
			end
			default: ;
		endcase
		if (w.stack_select)
			n_two = cnt;
		else
			n_one = cnt;
		r.size_one = n_one[8:0];
		r.size_two = n_two[8:0];
		return r;
	endfunction

	function automatic dir_row_t mk(input logic [1:0] op, input logic sel,
			input logic [31:0] val, input bit fixed, input logic [31:0] top,
			input logic [1:0] st, input logic [8:0] s1, input logic [8:0] s2);
		dir_row_t d;
		d.w.operation    = op;
		d.w.stack_select = sel;
		d.w.push_value   = val;
		d.fixed          = fixed;
		d.r.top_value    = top;
		d.r.status       = st;
		d.r.size_one     = s1;
		d.r.size_two     = s2;
		return d;
	endfunction

	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			default: return $urandom();
		endcase
	endfunction

	// push with the given chance, otherwise mostly pop or read top
	function automatic cmd_word_t rand_word(input int push_pct, input logic sel);
		cmd_word_t w;
		int        r;
		r              = $urandom_range(0, 99);
		w.stack_select = sel;
		w.push_value   = rand_value();
		if (r < push_pct)
			w.operation = OP_PUSH;
		else if (r >= 95)
			w.operation = OP_NONE;
		else
			w.operation = ($urandom_range(0, 2) == 0) ? OP_TOP : OP_POP;
		return w;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 88)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 40);
	endfunction

	// offer one word, record its expected response once taken
	task automatic issue(input cmd_word_t w, input bit fixed, input rsp_word_t typed);
		rsp_word_t predicted;
		int        gap;
		cmd       <= w;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		predicted = step_stacks(w);
		expected_q.insert(expected_q.size(), fixed ? typed : predicted);
		items_sent++;
		gap = burst_mode ? 0 : pick_gap();
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		cmd_valid <= 1'b0;
		do
			@(posedge clk);
		while (expected_q.size() != 0);
	endtask

	// fill until the stacks meet, push into the full buffer, then empty both
	task automatic fill_and_drain(input int kind);
		logic sel;
		while (n_one + n_two < DEPTH) begin
			sel = (kind == 2) ? 1'($urandom_range(0, 1)) : 1'(kind);
			issue(rand_word(90, sel), 1'b0, '0);
		end
		repeat (3) issue(rand_word(100, 1'($urandom_range(0, 1))), 1'b0, '0);
		while (n_one != 0 || n_two != 0) begin
			if (n_one == 0)
				sel = 1'b1;
			else if (n_two == 0)
				sel = 1'b0;
			else
				sel = 1'($urandom_range(0, 1));
			issue(rand_word(0, sel), 1'b0, '0);
		end
	endtask

	// field compare
	task automatic cmp_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h",
				$time, field, want, got);
			fail_count++;
		end
	endtask

	// response checker
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected response word, expected none, actual %h",
					$time, rsp);
				fail_count++;
			end else begin
				want_rsp = expected_q[0];
				expected_q.delete(0);
				cmp_field("top_value", want_rsp.top_value, rsp.top_value);
				cmp_field("status", 32'(want_rsp.status), 32'(rsp.status));
				cmp_field("size_one", 32'(want_rsp.size_one), 32'(rsp.size_one));
				cmp_field("size_two", 32'(want_rsp.size_two), 32'(rsp.size_two));
			end
		end
	end

	// watchdog on cycles with no word moving
	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == IDLE_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// response side stalls, with one long hold-off on request
	initial begin
		int run;
		bit s;
		rsp_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_now) begin
				s        = 1'b1;
				run      = HOLD_CYCLES;
				hold_now = 1'b0;
			end else begin
				s = ($urandom_range(0, 2) == 0);
				if (s)
					run = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
						: $urandom_range(1, 3);
				else
					run = $urandom_range(1, 20);
			end
			rsp_stall <= s;
			repeat (run) @(posedge clk);
		end
	end

	// stimulus
	initial begin
		int phase;
		cmd_valid <= 1'b0;
		cmd       <= '0;
		arst_n    <= 1'b0;

		// directed words: empty stacks, extremes, both stacks, no-op code
		dir_rows = '{
			mk(OP_POP,  1'b0, 32'h0000_0000, 1, 32'h0,         STAT_UNDER, 9'd0, 9'd0),
			mk(OP_TOP,  1'b1, 32'hFFFF_FFFF, 1, 32'h0,         STAT_UNDER, 9'd0, 9'd0),
			mk(OP_NONE, 1'b0, 32'h1234_5678, 1, 32'h0,         STAT_OK,    9'd0, 9'd0),
			mk(OP_PUSH, 1'b0, 32'hFFFF_FFFF, 1, 32'h0,         STAT_OK,    9'd1, 9'd0),
			mk(OP_PUSH, 1'b1, 32'h0000_0000, 1, 32'h0,         STAT_OK,    9'd1, 9'd1),
			mk(OP_PUSH, 1'b1, 32'h8000_0001, 1, 32'h0,         STAT_OK,    9'd1, 9'd2),
			mk(OP_TOP,  1'b0, 32'h0000_0000, 1, 32'hFFFF_FFFF, STAT_OK,    9'd1, 9'd2),
			mk(OP_TOP,  1'b1, 32'hDEAD_BEEF, 1, 32'h8000_0001, STAT_OK,    9'd1, 9'd2),
			mk(OP_NONE, 1'b1, 32'hFFFF_FFFF, 1, 32'h0,         STAT_OK,    9'd1, 9'd2),
			mk(OP_POP,  1'b1, 32'h0000_0000, 1, 32'h8000_0001, STAT_OK,    9'd1, 9'd1),
			mk(OP_POP,  1'b1, 32'h0000_0000, 1, 32'h0,         STAT_OK,    9'd1, 9'd0),
			mk(OP_POP,  1'b1, 32'h0000_0000, 1, 32'h0,         STAT_UNDER, 9'd1, 9'd0),
			mk(OP_TOP,  1'b1, 32'h0000_0000, 1, 32'h0,         STAT_UNDER, 9'd1, 9'd0),
			mk(OP_POP,  1'b0, 32'h0000_0000, 1, 32'hFFFF_FFFF, STAT_OK,    9'd0, 9'd0),
			mk(OP_POP,  1'b0, 32'h0000_0000, 1, 32'h0,         STAT_UNDER, 9'd0, 9'd0),
			mk(OP_PUSH, 1'b0, 32'h5555_AAAA, 0, 32'h0,         STAT_OK,    9'd0, 9'd0),
			mk(OP_PUSH, 1'b1, 32'hAAAA_5555, 0, 32'h0,         STAT_OK,    9'd0, 9'd0),
			mk(OP_TOP,  1'b0, 32'hFFFF_FFFF, 0, 32'h0,         STAT_OK,    9'd0, 9'd0),
			mk(OP_POP,  1'b1, 32'h0000_0000, 0, 32'h0,         STAT_OK,    9'd0, 9'd0),
			mk(OP_POP,  1'b0, 32'h0000_0000, 0, 32'h0,         STAT_OK,    9'd0, 9'd0)
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			issue(dir_rows[i].w, dir_rows[i].fixed, dir_rows[i].r);

		// long response hold-off while words keep coming back to back
		hold_now = 1'b1;
		cmd_valid <= 1'b0;
		do
			@(posedge clk);
		while (hold_now);
		burst_mode = 1'b1;
		repeat (30) issue(rand_word(60, 1'($urandom_range(0, 1))), 1'b0, '0);
		burst_mode = 1'b0;

		// sender waits for every outstanding response
		wait_drained();

		// random phases: mixed traffic, with full fills of each stack and of both
		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			burst_mode = ($urandom_range(0, 3) == 0);
			if (phase % 2 == 1 && phase < 6)
				fill_and_drain(phase / 2);
			else
				repeat ($urandom_range(50, 120))
					issue(rand_word(45, 1'($urandom_range(0, 1))), 1'b0, '0);
			burst_mode = 1'b0;
			if ($urandom_range(0, 3) == 0)
				wait_drained();
			phase++;
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule

// ===== dual_stack_shared_buffer.f =====
rtl/core/dss_pkg.sv
rtl/core/dss_datapath.sv
rtl/core/dss_ctrl.sv
rtl/core/dual_stack_shared_buffer.sv
bench/tb.sv
